>>> sv/cesd_pkg.sv
// Package for the C escape sequence decoder.
// Holds the parse phase codes, character constants, the result beat type
// and the hex digit helper. No dependencies.
package cesd_pkg;

  localparam int PhaseW = 3;
  localparam logic [PhaseW-1:0] PH_PLAIN = 3'd0;
  localparam logic [PhaseW-1:0] PH_ESC   = 3'd1;
  localparam logic [PhaseW-1:0] PH_HEX1  = 3'd2;
  localparam logic [PhaseW-1:0] PH_HEX2  = 3'd3;
  localparam logic [PhaseW-1:0] PH_OCT   = 3'd4;

  localparam logic [7:0] CH_A      = 8'h61;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_V      = 8'h76;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_THREE  = 8'h33;
  localparam logic [7:0] CH_SEVEN  = 8'h37;
  localparam logic [7:0] CH_NUL    = 8'h00;

  localparam logic [7:0] CODE_BEL = 8'd7;
  localparam logic [7:0] CODE_BS  = 8'd8;
  localparam logic [7:0] CODE_FF  = 8'd12;
  localparam logic [7:0] CODE_LF  = 8'h0a;
  localparam logic [7:0] CODE_CR  = 8'd13;
  localparam logic [7:0] CODE_HT  = 8'd9;
  localparam logic [7:0] CODE_VT  = 8'd11;

  localparam int QueueDepth = 4;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       end_of_string;
    logic       run_last;
  } result_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } hex_t;

  function automatic hex_t hex_digit(input logic [7:0] b);
    hex_t h;
    h.ok = 1'b1;
    h.value = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      h.value = 4'(b - 8'h30);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      h.value = 4'(b - 8'h61 + 8'd10);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      h.value = 4'(b - 8'h41 + 8'd10);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage

>>> sv/c_escape_sequence_decoder_top.sv
// Top level of the C escape sequence decoder.
// Decodes one literal byte per beat into zero, one or two result beats.
// Depends on cesd_pkg.
//
// The input channel (in_valid, in_ready, in_byte, in_last) carries the text
// of a quoted C literal, one byte per beat, with in_last on the final byte.
// The output channel (out_valid, out_ready) carries decoded bytes with
// byte_valid, end_of_string on the final result of a string, and run_last
// on the last result that one input beat caused.
// Each accepted byte is decoded in the cycle it is accepted and its results
// are written into a four-entry result queue, from which the output is read.
// One input beat is taken per cycle as long as each byte gives at most one
// result and the receiver takes one result per cycle; a byte that gives two
// results fills two queue entries. The queue sets in_ready: a byte is taken
// only while at least two entries are free, so a stalled receiver holds back
// the input once three or more result beats are queued. Reset empties the
// queue and returns the parser to the start of a string.
module c_escape_sequence_decoder_top
  import cesd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       byte_valid,
  output logic       end_of_string,
  output logic       run_last
);

  localparam int PtrW = $clog2(QueueDepth);
  localparam int CntW = $clog2(QueueDepth + 1);

  logic [PhaseW-1:0] phase, phase_next;
  logic [7:0]        pending, pending_next;
  logic [1:0]        digits, digits_next;
  logic              at_start, at_start_next;
  logic              ended, ended_next;

  result_t           queue [QueueDepth];
  logic [PtrW-1:0]   wr_ptr, rd_ptr;
  logic [CntW-1:0]   count;

  logic              accept, pop;
  logic [1:0]        nres;
  logic [7:0]        res0, res1;
  logic              res0_valid, res1_valid;
  logic              do_plain;
  hex_t              hx;
  logic [7:0]        oct_value;
  result_t           r0, r1;

  assign accept = in_valid && in_ready;
  assign pop    = out_valid && out_ready;
  assign in_ready  = count <= CntW'(QueueDepth - 2);
  assign out_valid = count != '0;

  assign out_byte      = queue[rd_ptr].out_byte;
  assign byte_valid    = queue[rd_ptr].byte_valid;
  assign end_of_string = queue[rd_ptr].end_of_string;
  assign run_last      = queue[rd_ptr].run_last;

  always_comb begin
    phase_next    = phase;
    pending_next  = pending;
    digits_next   = digits;
    at_start_next = at_start;
    ended_next    = ended;
    nres       = 2'd0;
    res0       = 8'd0;
    res1       = 8'd0;
    res0_valid = 1'b0;
    res1_valid = 1'b0;
    do_plain   = 1'b0;
    hx         = hex_digit(in_byte);
    oct_value  = 8'((pending << 3) + (in_byte - CH_ZERO));

    if (!ended) begin
      case (phase)
        PH_ESC: begin
          phase_next = PH_PLAIN;
          case (in_byte)
            CH_A: begin res0 = CODE_BEL; nres = 2'd1; end
            CH_B: begin res0 = CODE_BS;  nres = 2'd1; end
            CH_F: begin res0 = CODE_FF;  nres = 2'd1; end
            CH_N: begin res0 = CODE_LF;  nres = 2'd1; end
            CH_R: begin res0 = CODE_CR;  nres = 2'd1; end
            CH_T: begin res0 = CODE_HT;  nres = 2'd1; end
            CH_V: begin res0 = CODE_VT;  nres = 2'd1; end
            CH_X: phase_next = PH_HEX1;
            CH_NUL: ended_next = 1'b1;
            default: begin
              if (in_byte inside {[CH_ZERO:CH_SEVEN]}) begin
                pending_next = in_byte - CH_ZERO;
                digits_next  = (in_byte <= CH_THREE) ? 2'd2 : 2'd1;
                phase_next   = PH_OCT;
              end else begin
                res0 = in_byte;
                nres = 2'd1;
              end
            end
          endcase
          res0_valid = nres != 2'd0;
        end
        PH_HEX1: begin
          if (hx.ok) begin
            pending_next = {4'd0, hx.value};
            phase_next   = PH_HEX2;
          end else begin
            res0 = CH_X;
            res0_valid = 1'b1;
            nres = 2'd1;
            do_plain = 1'b1;
          end
        end
        PH_HEX2: begin
          res0_valid = 1'b1;
          nres = 2'd1;
          if (hx.ok) begin
            res0 = {pending[3:0], hx.value};
            phase_next = PH_PLAIN;
          end else begin
            res0 = pending;
            do_plain = 1'b1;
          end
        end
        PH_OCT: begin
          if (in_byte inside {[CH_ZERO:CH_SEVEN]}) begin
            pending_next = oct_value;
            digits_next  = digits - 2'd1;
            if (digits == 2'd1) begin
              res0 = oct_value;
              res0_valid = 1'b1;
              nres = 2'd1;
              phase_next = PH_PLAIN;
            end
          end else begin
            res0 = pending;
            res0_valid = 1'b1;
            nres = 2'd1;
            do_plain = 1'b1;
          end
        end
        default: begin
          if (at_start && in_byte == CH_QUOTE) begin
            phase_next = PH_PLAIN;
          end else begin
            do_plain = 1'b1;
          end
        end
      endcase

      if (do_plain) begin
        phase_next = PH_PLAIN;
        if (in_byte == CH_NUL) begin
          ended_next = 1'b1;
        end else if (in_byte == CH_QUOTE && in_last) begin
          phase_next = PH_PLAIN;
        end else if (in_byte == CH_BSLASH) begin
          phase_next = PH_ESC;
        end else if (nres == 2'd0) begin
          res0 = in_byte;
          res0_valid = 1'b1;
          nres = 2'd1;
        end else begin
          res1 = in_byte;
          res1_valid = 1'b1;
          nres = 2'd2;
        end
      end
      at_start_next = 1'b0;
    end

    if (in_last) begin
      if (!ended_next && (phase_next == PH_HEX1 || phase_next == PH_HEX2 ||
                          phase_next == PH_OCT)) begin
        if (nres == 2'd0) begin
          res0 = (phase_next == PH_HEX1) ? CH_X : pending_next;
          res0_valid = 1'b1;
          nres = 2'd1;
        end else begin
          res1 = (phase_next == PH_HEX1) ? CH_X : pending_next;
          res1_valid = 1'b1;
          nres = 2'd2;
        end
      end
      if (nres == 2'd0) begin
        res0 = 8'd0;
        res0_valid = 1'b0;
        nres = 2'd1;
      end
      phase_next    = PH_PLAIN;
      pending_next  = 8'd0;
      digits_next   = 2'd0;
      at_start_next = 1'b1;
      ended_next    = 1'b0;
    end

    r0.out_byte      = res0;
    r0.byte_valid    = res0_valid;
    r0.end_of_string = in_last && nres == 2'd1;
    r0.run_last      = nres == 2'd1;
    r1.out_byte      = res1;
    r1.byte_valid    = res1_valid;
    r1.end_of_string = in_last;
    r1.run_last      = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_PLAIN;
      pending  <= 8'd0;
      digits   <= 2'd0;
      at_start <= 1'b1;
      ended    <= 1'b0;
      wr_ptr   <= '0;
      rd_ptr   <= '0;
      count    <= '0;
    end else begin
      if (accept) begin
        phase    <= phase_next;
        pending  <= pending_next;
        digits   <= digits_next;
        at_start <= at_start_next;
        ended    <= ended_next;
        wr_ptr   <= wr_ptr + PtrW'(nres);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PtrW'(1);
      end
      count <= count + (accept ? CntW'(nres) : CntW'(0)) - (pop ? CntW'(1) : CntW'(0));
    end
  end

  always_ff @(posedge clk) begin
    if (accept && nres != 2'd0) begin
      queue[wr_ptr] <= r0;
    end
    if (accept && nres == 2'd2) begin
      queue[wr_ptr + PtrW'(1)] <= r1;
    end
  end

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for c_escape_sequence_decoder_top.
// Sends quoted C literals byte by byte, predicts the decoded result beats
// and checks each one as it leaves; depends on cesd_pkg and the RTL only.
module tb_top;
  import cesd_pkg::*;

  localparam int IdleLimit = 2000;
  localparam int HoldLen = 48;
  localparam int RandItems = 2000;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_F = 8'h46;
  localparam logic [7:0] EscLetters [7] = '{CH_A, CH_B, CH_F, CH_N, CH_R, CH_T, CH_V};

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       pause;
  } lit_item_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte = 8'h00;
  logic       in_last = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       end_of_string;
  logic       run_last;

  lit_item_t  lit_q[$];
  result_t    unescaped_q[$];
  result_t    step_q[$];

  logic [PhaseW-1:0] ph;
  logic [7:0]        acc;
  logic [1:0]        octs_left;
  logic              fresh;
  logic              halted;

  logic in_taken = 1'b0;
  int   stim_total = 0;
  int   strings_sent = 0;
  int   items_in = 0;
  int   beats_out = 0;
  int   mismatches = 0;
  int   idle_cycles = 0;
  int   burst_left = 0;
  int   gap_left = 0;
  int   pauses_done = 0;
  int   hold_left = 0;
  int   next_hold = 300;
  int   holds_done = 0;
  int   rx_mode = 0;
  int   rx_mode_left = 0;

  c_escape_sequence_decoder_top i_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_byte       (in_byte),
    .in_last       (in_last),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .byte_valid    (byte_valid),
    .end_of_string (end_of_string),
    .run_last      (run_last)
  );

  always #2 clk = ~clk;

  task automatic restart_parse();
    ph = PH_PLAIN;
    acc = 8'h00;
    octs_left = 2'd0;
    fresh = 1'b1;
    halted = 1'b0;
  endtask

  task automatic put_char(input logic [7:0] v);
    step_q.push_back('{out_byte: v, byte_valid: 1'b1, end_of_string: 1'b0, run_last: 1'b0});
  endtask

  task automatic take_plain(input logic [7:0] b, input logic l);
    ph = PH_PLAIN;
    if (b == CH_NUL) begin
      halted = 1'b1;
    end else if (!(b == CH_QUOTE && l)) begin
      if (b == CH_BSLASH) begin
        ph = PH_ESC;
      end else begin
        put_char(b);
      end
    end
  endtask

  task automatic unescape_byte(input logic [7:0] b, input logic l);
    int      hv;
    logic    is_oct;
    result_t r;
    hv = -1;
    if (b >= CH_ZERO && b <= CH_NINE) begin
      hv = b - CH_ZERO;
    end else if (b >= CH_A && b <= CH_F) begin
      hv = b - CH_A + 10;
    end else if (b >= CH_UPPER_A && b <= CH_UPPER_F) begin
      hv = b - CH_UPPER_A + 10;
    end
    is_oct = (b >= CH_ZERO && b <= CH_SEVEN);
    step_q.delete();
    if (!halted) begin
      case (ph)
        PH_ESC: begin
          ph = PH_PLAIN;
          case (b)
            CH_A: put_char(CODE_BEL);
            CH_B: put_char(CODE_BS);
            CH_F: put_char(CODE_FF);
            CH_N: put_char(CODE_LF);
            CH_R: put_char(CODE_CR);
            CH_T: put_char(CODE_HT);
            CH_V: put_char(CODE_VT);
            CH_X: ph = PH_HEX1;
            CH_NUL: halted = 1'b1;
            default: begin
              if (is_oct) begin
                acc = b - CH_ZERO;
                octs_left = (b <= CH_THREE) ? 2'd2 : 2'd1;
                ph = PH_OCT;
              end else begin
                put_char(b);
              end
            end
          endcase
        end
        PH_HEX1: begin
          if (hv >= 0) begin
            acc = 8'(hv);
            ph = PH_HEX2;
          end else begin
            put_char(CH_X);
            take_plain(b, l);
          end
        end
        PH_HEX2: begin
          if (hv >= 0) begin
            put_char({acc[3:0], 4'(hv)});
            ph = PH_PLAIN;
          end else begin
            put_char(acc);
            take_plain(b, l);
          end
        end
        PH_OCT: begin
          if (is_oct) begin
            acc = (acc << 3) + (b - CH_ZERO);
            octs_left = octs_left - 2'd1;
            if (octs_left == 2'd0) begin
              put_char(acc);
              ph = PH_PLAIN;
            end
          end else begin
            put_char(acc);
            take_plain(b, l);
          end
        end
        default: begin
          if (fresh && b == CH_QUOTE) begin
            ph = PH_PLAIN;
          end else begin
            take_plain(b, l);
          end
        end
      endcase
      fresh = 1'b0;
    end
    if (l) begin
      if (!halted) begin
        if (ph == PH_HEX1) begin
          put_char(CH_X);
        end else if (ph == PH_HEX2 || ph == PH_OCT) begin
          put_char(acc);
        end
      end
      if (step_q.size() == 0) begin
        step_q.push_back('0);
      end
      r = step_q.pop_back();
      r.end_of_string = 1'b1;
      step_q.push_back(r);
      restart_parse();
    end
    if (step_q.size() > 0) begin
      r = step_q.pop_back();
      r.run_last = 1'b1;
      step_q.push_back(r);
    end
    foreach (step_q[i]) begin
      unescaped_q.push_back(step_q[i]);
    end
  endtask

  task automatic note_mismatch(input string why, input result_t want, input result_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("Mismatch on result beat %0d (%s): expected byte %02h valid %b eos %b last %b, got byte %02h valid %b eos %b last %b",
               beats_out, why, want.out_byte, want.byte_valid, want.end_of_string,
               want.run_last, got.out_byte, got.byte_valid, got.end_of_string, got.run_last);
    end
  endtask

  task automatic push_ch(input logic [7:0] b, input logic l);
    lit_q.push_back('{ch: b, last: l, pause: 1'b0});
    stim_total++;
    if (l) begin
      strings_sent++;
    end
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      push_ch(s[i], i == s.len() - 1);
    end
  endtask

  always @(posedge clk) begin
    result_t got;
    result_t want;
    string   why;
    if (rst) begin
      in_taken <= 1'b0;
      restart_parse();
    end else begin
      in_taken <= in_valid && in_ready;
      if (out_valid && out_ready) begin
        got = '{out_byte: out_byte, byte_valid: byte_valid,
                end_of_string: end_of_string, run_last: run_last};
        if (unescaped_q.size() == 0) begin
          note_mismatch("no result expected", '0, got);
        end else begin
          want = unescaped_q.pop_front();
          why = "";
          if (got.out_byte !== want.out_byte) why = {why, " out_byte"};
          if (got.byte_valid !== want.byte_valid) why = {why, " byte_valid"};
          if (got.end_of_string !== want.end_of_string) why = {why, " end_of_string"};
          if (got.run_last !== want.run_last) why = {why, " run_last"};
          if (why != "") begin
            note_mismatch({"wrong", why}, want, got);
          end
        end
        beats_out <= beats_out + 1;
      end
      if (in_valid && in_ready) begin
        unescape_byte(in_byte, in_last);
        items_in <= items_in + 1;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (lit_q.size() == 0) begin
        in_valid <= 1'b0;
      end else if (lit_q[0].pause) begin
        in_valid <= 1'b0;
        if (unescaped_q.size() == 0) begin
          void'(lit_q.pop_front());
          pauses_done <= pauses_done + 1;
        end
      end else begin
        in_valid <= 1'b1;
        in_byte <= lit_q[0].ch;
        in_last <= lit_q[0].last;
        void'(lit_q.pop_front());
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (beats_out >= next_hold && in_valid) begin
      out_ready <= 1'b0;
      hold_left <= HoldLen - 1;
      next_hold <= next_hold + 600;
      holds_done <= holds_done + 1;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode <= $urandom_range(0, 3);
        rx_mode_left <= $urandom_range(8, 64);
      end else begin
        rx_mode_left <= rx_mode_left - 1;
      end
      case (rx_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        2: out_ready <= ($urandom_range(0, 7) == 0);
        default: out_ready <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("Timeout: no beat moved for %0d cycles, %0d results still due",
               IdleLimit, unescaped_q.size());
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int         kind;
    int         k;
    int         start;
    int         rand_items;
    int         next_pause;
    logic [7:0] b;
    rand_items = 0;
    next_pause = 0;

    add_text("\"\\t\\x7\"");
    add_text("\\377\\400");
    add_text("\\x");
    add_text("\\");
    push_ch(8'hFF, 1'b0);
    push_ch(CH_BSLASH, 1'b0);
    push_ch(CH_NUL, 1'b0);
    push_ch(8'hFF, 1'b0);
    push_ch(CH_QUOTE, 1'b1);
    push_ch(CH_QUOTE, 1'b0);
    push_ch(CH_QUOTE, 1'b0);
    push_ch(CH_NUL, 1'b0);
    push_ch(CH_A, 1'b1);

    while (rand_items < RandItems) begin
      if (rand_items >= next_pause) begin
        lit_q.push_back('{ch: 8'h00, last: 1'b0, pause: 1'b1});
        next_pause += 500;
      end
      start = stim_total;
      if ($urandom_range(0, 1) == 1) begin
        push_ch(CH_QUOTE, 1'b0);
      end
      repeat ($urandom_range(1, 10)) begin
        kind = $urandom_range(0, 99);
        if (kind < 40) begin
          b = 8'($urandom_range(8'h20, 8'h7E));
          push_ch((b == CH_BSLASH) ? CH_A : b, 1'b0);
        end else if (kind < 55) begin
          push_ch(CH_BSLASH, 1'b0);
          push_ch(EscLetters[$urandom_range(0, 6)], 1'b0);
        end else if (kind < 67) begin
          push_ch(CH_BSLASH, 1'b0);
          push_ch(CH_X, 1'b0);
          repeat ($urandom_range(0, 2)) begin
            k = $urandom_range(0, 21);
            if (k < 10) begin
              b = CH_ZERO + 8'(k);
            end else if (k < 16) begin
              b = CH_A + 8'(k - 10);
            end else begin
              b = CH_UPPER_A + 8'(k - 16);
            end
            push_ch(b, 1'b0);
          end
        end else if (kind < 79) begin
          push_ch(CH_BSLASH, 1'b0);
          repeat ($urandom_range(1, 3)) begin
            push_ch(CH_ZERO + 8'($urandom_range(0, 7)), 1'b0);
          end
        end else if (kind < 87) begin
          push_ch(CH_BSLASH, 1'b0);
          push_ch(8'($urandom_range(1, 255)), 1'b0);
        end else if (kind < 95) begin
          push_ch(8'($urandom_range(1, 255)), 1'b0);
        end else if (kind < 98) begin
          push_ch(CH_QUOTE, 1'b0);
        end else begin
          if ($urandom_range(0, 1) == 1) begin
            push_ch(CH_BSLASH, 1'b0);
          end
          push_ch(CH_NUL, 1'b0);
        end
      end
      kind = $urandom_range(0, 9);
      if (kind < 5) begin
        push_ch(CH_QUOTE, 1'b1);
      end else if (kind < 8) begin
        push_ch(8'($urandom_range(0, 255)), 1'b1);
      end else begin
        push_ch(CH_BSLASH, 1'b1);
      end
      rand_items += stim_total - start;
    end

    repeat (10) @(negedge clk);
    rst <= 1'b0;
    while (items_in != stim_total || unescaped_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    $display("Decoded %0d bytes in %0d literals into %0d result beats.",
             items_in, strings_sent, beats_out);
    $display("Output held off %0d times for %0d cycles; input drained %0d times.",
             holds_done, HoldLen, pauses_done);
    if (mismatches == 0 && unescaped_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, unescaped_q.size());
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
